[hw/rtl/dar_pkg.sv]
// Shared constants, types and command codes for the device access rule table.
package dar_pkg;

  // Table geometry
  localparam int TABLE_ENTRIES = 64;
  localparam int IDX_W = $clog2(TABLE_ENTRIES);
  localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);

  // Field widths
  localparam int CMD_W = 3;
  localparam int TYPE_W = 2;
  localparam int MAJOR_W = 12;
  localparam int MINOR_W = 20;
  localparam int ACC_W = 7;

  // Command codes
  localparam logic [CMD_W-1:0] CMD_CHECK = 3'd0;
  localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
  localparam logic [CMD_W-1:0] CMD_CHANGE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd3;
  localparam logic [CMD_W-1:0] CMD_CLEAN = 3'd4;

  // Device type codes
  localparam logic [TYPE_W-1:0] KIND_BLOCK = 2'd0;
  localparam logic [TYPE_W-1:0] KIND_CHAR = 2'd1;
  localparam logic [TYPE_W-1:0] KIND_ALL = 2'd2;

  // Access bits
  localparam logic [ACC_W-1:0] PERM_WRITE = 7'h04;
  localparam logic [ACC_W-1:0] PERM_MOUNT = 7'h40;

  // One stored rule (43 bits)
  typedef struct packed {
    logic [TYPE_W-1:0] dev_kind;
    logic [MAJOR_W-1:0] major;
    logic major_any;
    logic [MINOR_W-1:0] minor;
    logic minor_any;
    logic [ACC_W-1:0] access;
  } rule_t;

  // Controller to datapath commands
  typedef struct packed {
    logic start;            // latch the incoming transaction
    logic issue;            // read table entry at rd_addr
    logic [IDX_W-1:0] rd_addr;
    logic finish;           // append / clean, load result register
  } dar_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic scan_cmd;         // latched command walks the table
  } dar_sts_t;

endpackage

[hw/rtl/device_access_rule_table.sv]
// Top level of the device access rule table: controller plus datapath.
//
//  channel  | handshake                | payload
//  ---------+--------------------------+----------------------------------------------
//  in       | in_valid / in_stall      | cmd, dev_kind, major, major_any, minor,
//           |                          | minor_any, access
//  out      | out_valid / out_stall    | allowed, status
//  cfg      | cfg_wr_en                | cfg_wr_data (default_deny)
//
// Check, add, change and remove walk all 64 entries through the single read port
// of the rule memory, then pass through the finish step and return to idle.
// Clean and unused commands skip the table walk and go straight to the finish step.
// rst is synchronous: the table is empty and default_deny is 0 after reset.
// A new transaction is taken while a finished result waits; the next result
// waits in the finish step until out_stall lets the held one go.
module device_access_rule_table (
  input  logic clk,
  input  logic rst,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic in_valid,
  output logic in_stall,
  input  logic [dar_pkg::CMD_W-1:0] cmd,
  input  logic [dar_pkg::TYPE_W-1:0] dev_kind,
  input  logic [dar_pkg::MAJOR_W-1:0] major,
  input  logic major_any,
  input  logic [dar_pkg::MINOR_W-1:0] minor,
  input  logic minor_any,
  input  logic [dar_pkg::ACC_W-1:0] access,
  output logic out_valid,
  input  logic out_stall,
  output logic allowed,
  output logic status
);

  dar_pkg::dar_cmd_t ctl;
  dar_pkg::dar_sts_t sts;

  dar_ctrl u_ctrl (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .ctl(ctl),
    .sts(sts)
  );

  dar_datapath u_datapath (
    .clk(clk),
    .rst(rst),
    .ctl(ctl),
    .sts(sts),
    .cfg_wr_en(cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd(cmd),
    .dev_kind(dev_kind),
    .major(major),
    .major_any(major_any),
    .minor(minor),
    .minor_any(minor_any),
    .access(access),
    .allowed(allowed),
    .status(status)
  );

endmodule

[hw/rtl/dar_ctrl.sv]
// Controller: accepts transactions, sequences the table scan, owns the output valid.
module dar_ctrl (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  output dar_pkg::dar_cmd_t ctl,
  input  dar_pkg::dar_sts_t sts
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_DONE = 2'd2;

  logic [1:0] state;
  logic [1:0] state_next;
  logic [dar_pkg::CNT_W-1:0] cnt;
  logic [dar_pkg::CNT_W-1:0] cnt_next;
  logic scan_last;
  logic out_free;

  assign in_stall = (state != S_IDLE);
  assign scan_last = (cnt == dar_pkg::CNT_W'(dar_pkg::TABLE_ENTRIES));
  assign out_free = !out_valid || !out_stall;

  // Next state and command decode
  always_comb begin
    state_next = state;
    cnt_next = cnt;
    ctl = '0;
    ctl.rd_addr = cnt[dar_pkg::IDX_W-1:0];
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          ctl.start = 1'b1;
          cnt_next = '0;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts.scan_cmd || scan_last) begin
          state_next = S_DONE;
        end else begin
          ctl.issue = 1'b1;
          cnt_next = cnt + 1'b1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          ctl.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
    end else begin
      state <= state_next;
      cnt <= cnt_next;
    end
  end

  // Output valid: set on finish, cleared when the result is taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.finish) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

endmodule

[hw/rtl/dar_datapath.sv]
// Datapath: rule memory, valid bits, match logic, write-back, append and result.
module dar_datapath (
  input  logic clk,
  input  logic rst,
  input  dar_pkg::dar_cmd_t ctl,
  output dar_pkg::dar_sts_t sts,
  input  logic cfg_wr_en,
  input  logic cfg_wr_data,
  input  logic [dar_pkg::CMD_W-1:0] cmd,
  input  logic [dar_pkg::TYPE_W-1:0] dev_kind,
  input  logic [dar_pkg::MAJOR_W-1:0] major,
  input  logic major_any,
  input  logic [dar_pkg::MINOR_W-1:0] minor,
  input  logic minor_any,
  input  logic [dar_pkg::ACC_W-1:0] access,
  output logic allowed,
  output logic status
);

  // Rule store and valid bits
  dar_pkg::rule_t mem [dar_pkg::TABLE_ENTRIES];
  logic [dar_pkg::TABLE_ENTRIES-1:0] rule_valid;

  logic default_deny;

  // Latched transaction
  logic [dar_pkg::CMD_W-1:0] q_cmd;
  dar_pkg::rule_t q;

  // Read pipeline
  dar_pkg::rule_t rd_data;
  logic rd_ok;
  logic [dar_pkg::IDX_W-1:0] rd_idx;

  // Scan results
  logic hit;
  logic free_found;
  logic [dar_pkg::IDX_W-1:0] free_idx;

  // Evaluation of the entry just read
  logic ent_valid;
  logic key_eq;
  logic chk_hit;
  logic type_ok;
  logic num_ok;
  logic [dar_pkg::ACC_W-1:0] miss;
  logic mount_ok;
  logic [dar_pkg::ACC_W-1:0] acc_rm;
  logic need_append;

  // Memory write port
  logic wr_en;
  logic [dar_pkg::IDX_W-1:0] wr_addr;
  dar_pkg::rule_t wr_data;

  // Valid bit updates
  logic vclr;
  logic vset;

  assign sts.scan_cmd = (q_cmd == dar_pkg::CMD_CHECK) || (q_cmd == dar_pkg::CMD_ADD) ||
                        (q_cmd == dar_pkg::CMD_CHANGE) || (q_cmd == dar_pkg::CMD_REMOVE);

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      default_deny <= 1'b0;
    end else if (cfg_wr_en) begin
      default_deny <= cfg_wr_data;
    end
  end

  // Latch the transaction; wildcard numbers are held as zero
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      q_cmd <= cmd;
      q.dev_kind <= dev_kind;
      q.major <= major_any ? '0 : major;
      q.major_any <= major_any;
      q.minor <= minor_any ? '0 : minor;
      q.minor_any <= minor_any;
      q.access <= access;
    end
  end

  // Match logic
  always_comb begin
    ent_valid = rd_ok && rule_valid[rd_idx];
    key_eq = (rd_data.dev_kind == q.dev_kind) && (rd_data.major_any == q.major_any) &&
             (rd_data.minor_any == q.minor_any) && (rd_data.major == q.major) &&
             (rd_data.minor == q.minor);
    type_ok = !((q.dev_kind == dar_pkg::KIND_BLOCK) &&
                (rd_data.dev_kind != dar_pkg::KIND_BLOCK)) &&
              !((q.dev_kind == dar_pkg::KIND_CHAR) &&
                (rd_data.dev_kind != dar_pkg::KIND_CHAR));
    num_ok = (rd_data.major_any || (!q.major_any && (rd_data.major == q.major))) &&
             (rd_data.minor_any || (!q.minor_any && (rd_data.minor == q.minor)));
    miss = q.access & ~rd_data.access & ~dar_pkg::PERM_MOUNT;
    mount_ok = ((miss & ~dar_pkg::PERM_WRITE) == '0) &&
               ((rd_data.access & dar_pkg::PERM_MOUNT) != '0) &&
               ((q.access & dar_pkg::PERM_MOUNT) != '0);
    chk_hit = ((rd_data.dev_kind == dar_pkg::KIND_ALL) || (type_ok && num_ok)) &&
              ((miss == '0) || mount_ok);
    acc_rm = rd_data.access & ~q.access;
    need_append = !hit && ((q_cmd == dar_pkg::CMD_ADD) ||
                  ((q_cmd == dar_pkg::CMD_CHANGE) && (q.access != '0)));
  end

  // Write-back during the scan, append at finish
  always_comb begin
    wr_en = 1'b0;
    wr_addr = rd_idx;
    wr_data = rd_data;
    vclr = 1'b0;
    vset = 1'b0;
    if (ent_valid) begin
      case (q_cmd)
        dar_pkg::CMD_ADD: begin
          if (key_eq) begin
            wr_en = 1'b1;
            wr_data.access = rd_data.access | q.access;
          end
        end
        dar_pkg::CMD_CHANGE: begin
          if (key_eq) begin
            if (q.access == '0) begin
              vclr = 1'b1;
            end else begin
              wr_en = 1'b1;
              wr_data.access = q.access;
            end
          end
        end
        dar_pkg::CMD_REMOVE: begin
          if (key_eq || (rd_data.dev_kind == dar_pkg::KIND_ALL)) begin
            wr_en = 1'b1;
            wr_data.access = acc_rm;
            vclr = (acc_rm == '0);
          end
        end
        default: ;
      endcase
    end
    if (ctl.finish && need_append && free_found) begin
      wr_en = 1'b1;
      wr_addr = free_idx;
      wr_data = q;
      vset = 1'b1;
    end
  end

  // Rule memory: one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.issue) begin
      rd_data <= mem[ctl.rd_addr];
    end
  end

  // Read pipeline tag
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_ok <= 1'b0;
    end else begin
      rd_ok <= ctl.issue;
    end
    if (ctl.issue) begin
      rd_idx <= ctl.rd_addr;
    end
  end

  // Valid bits
  always_ff @(posedge clk) begin
    if (rst) begin
      rule_valid <= '0;
    end else if (ctl.finish && (q_cmd == dar_pkg::CMD_CLEAN)) begin
      rule_valid <= '0;
    end else if (vclr) begin
      rule_valid[rd_idx] <= 1'b0;
    end else if (vset) begin
      rule_valid[free_idx] <= 1'b1;
    end
  end

  // Scan accumulators: any match, lowest free slot
  always_ff @(posedge clk) begin
    if (ctl.start) begin
      hit <= 1'b0;
      free_found <= 1'b0;
      free_idx <= '0;
    end else if (rd_ok) begin
      if (ent_valid) begin
        if (q_cmd == dar_pkg::CMD_CHECK) begin
          if (chk_hit) begin
            hit <= 1'b1;
          end
        end else if (key_eq) begin
          hit <= 1'b1;
        end
      end
      if (!rule_valid[rd_idx] && !free_found) begin
        free_found <= 1'b1;
        free_idx <= rd_idx;
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      allowed <= (q_cmd == dar_pkg::CMD_CHECK) && (default_deny == hit);
      status <= need_append && !free_found;
    end
  end

endmodule
